### sv/csvw_pkg.sv
// shared types, codes and helpers for the csv field quoting writer
package csvw_pkg;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_NULL     = 2'd2;
    localparam logic [1:0] KIND_ROW_END  = 2'd3;

    localparam logic [2:0] REG_DELIMITER    = 3'd0;
    localparam logic [2:0] REG_QUOTE_MARK   = 3'd1;
    localparam logic [2:0] REG_ALWAYS_QUOTE = 3'd2;
    localparam logic [2:0] REG_USE_CRLF     = 3'd3;
    localparam logic [2:0] REG_NULL_TEXT    = 3'd4;
    localparam logic [2:0] REG_NULL_LENGTH  = 3'd5;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] RESET_DELIMITER  = 8'd44;
    localparam logic [7:0] RESET_QUOTE_MARK = 8'd34;
    localparam int         NULL_MAX_BYTES   = 8;
    localparam logic [3:0] NULL_MAX_LEN     = 4'd8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } csvw_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic        field_truncated;
        logic [31:0] rows_done;
    } csvw_out_t;

    // per-cycle control broadcast to every cell of the field chain
    typedef struct packed {
        logic       load;
        logic       clr;
        logic       pop;
        logic [7:0] load_byte;
    } chain_ctl_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } cell_t;

    function automatic logic is_special(input logic [7:0] b, input logic [7:0] delim,
                                        input logic [7:0] qm);
        return (b == delim) || (b == qm) || (b == CHAR_CR) || (b == CHAR_LF);
    endfunction

endpackage

### sv/csv_field_quoting_writer_top.sv
// csv field quoting writer: field chain, emit sequencer and output register
// A field byte transaction is stored in the next free cell of the chain (bytes past
// MAX_FIELD_BYTES are dropped and flagged). End of field, null field and end of row are
// taken only when the sequencer is idle and then emit one byte per cycle while the
// output register drains. Bytes leave from the chain head, the whole row of cells
// shifting one place per stored byte sent; the output register lets a new transaction
// be taken while the last result still waits.
module csv_field_quoting_writer_top
    import csvw_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  csvw_in_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output csvw_out_t   out_item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DELIM  = 7'b0000010,
        ST_OPENQ  = 7'b0000100,
        ST_BODY   = 7'b0001000,
        ST_CLOSEQ = 7'b0010000,
        ST_CR     = 7'b0100000,
        ST_LF     = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  delim_reg, quote_reg;
    logic        aq_reg, crlf_reg;
    logic [63:0] null_text_reg;
    logic [3:0]  null_len_reg;
    logic        special_reg, special_next;
    logic        ovf_reg, ovf_next;
    logic        rhf_reg, rhf_next;
    logic [31:0] rows_reg, rows_next;
    logic        trunc_reg, trunc_next;
    logic        quote_on_reg, quote_on_next;
    logic        src_null_reg, src_null_next;
    logic        dbl_reg, dbl_next;
    logic [63:0] null_sh_reg, null_sh_next;
    logic [3:0]  ncnt_reg, ncnt_next;
    logic        out_valid_reg, out_valid_next;
    csvw_out_t   out_item_reg, out_item_next;

    chain_ctl_t  ctl;
    logic [7:0]  head;
    logic        head_valid, second_valid, full;

    logic        accept, emit_go;
    logic [3:0]  nlen;
    logic        nsp;
    logic        empty_i, quote_i;
    logic [7:0]  src_head;
    logic        src_empty, src_more;
    logic        body_pop;

    csvw_chain #(
        .Depth (MAX_FIELD_BYTES)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .head         (head),
        .head_valid   (head_valid),
        .second_valid (second_valid),
        .full         (full)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign emit_go   = (state_reg != ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign nlen = (null_len_reg > NULL_MAX_LEN) ? NULL_MAX_LEN : null_len_reg;

    always_comb
    begin
        nsp = 1'b0;
        for (int i = 0; i < NULL_MAX_BYTES; i++)
        begin
            if ((4'(i) < nlen) && is_special(null_text_reg[8*i +: 8], delim_reg, quote_reg))
            begin
                nsp = 1'b1;
            end
        end
    end

    assign empty_i   = (in_item.kind == KIND_FIELD_END) ? !head_valid : (nlen == 4'd0);
    assign quote_i   = aq_reg | ((in_item.kind == KIND_FIELD_END) ? special_reg : nsp);
    assign src_head  = src_null_reg ? null_sh_reg[7:0] : head;
    assign src_empty = src_null_reg ? (ncnt_reg == 4'd0) : !head_valid;
    assign src_more  = src_null_reg ? (ncnt_reg > 4'd1) : second_valid;
    // an inner quote mark is sent twice: first pass holds the byte
    assign body_pop  = !(quote_on_reg && (src_head == quote_reg) && !dbl_reg);

    always_comb
    begin
        ctl.load      = accept && (in_item.kind == KIND_BYTE);
        ctl.clr       = accept && (in_item.kind == KIND_NULL);
        ctl.pop       = emit_go && (state_reg == ST_BODY) && body_pop && !src_null_reg;
        ctl.load_byte = in_item.data_byte;
    end

    always_comb
    begin
        state_next     = state_reg;
        special_next   = special_reg;
        ovf_next       = ovf_reg;
        rhf_next       = rhf_reg;
        rows_next      = rows_reg;
        trunc_next     = trunc_reg;
        quote_on_next  = quote_on_reg;
        src_null_next  = src_null_reg;
        dbl_next       = dbl_reg;
        null_sh_next   = null_sh_reg;
        ncnt_next      = ncnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        if (accept)
        begin
            case (in_item.kind)
                KIND_BYTE:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (is_special(in_item.data_byte, delim_reg, quote_reg))
                    begin
                        special_next = 1'b1;
                    end
                end
                KIND_FIELD_END, KIND_NULL:
                begin
                    trunc_next    = (in_item.kind == KIND_FIELD_END) && ovf_reg;
                    src_null_next = (in_item.kind == KIND_NULL);
                    quote_on_next = quote_i;
                    null_sh_next  = null_text_reg;
                    ncnt_next     = nlen;
                    dbl_next      = 1'b0;
                    special_next  = 1'b0;
                    ovf_next      = 1'b0;
                    rhf_next      = 1'b1;
                    if (rhf_reg)
                    begin
                        state_next = ST_DELIM;
                    end
                    else if (quote_i)
                    begin
                        state_next = ST_OPENQ;
                    end
                    else if (!empty_i)
                    begin
                        state_next = ST_BODY;
                    end
                end
                KIND_ROW_END:
                begin
                    trunc_next = 1'b0;
                    rhf_next   = 1'b0;
                    rows_next  = rows_reg + 32'd1;
                    state_next = crlf_reg ? ST_CR : ST_LF;
                end
                default:
                begin
                end
            endcase
        end

        if (emit_go)
        begin
            out_valid_next                = 1'b1;
            out_item_next.field_truncated = trunc_reg;
            out_item_next.rows_done       = rows_reg;
            out_item_next.last            = 1'b0;
            out_item_next.out_byte        = src_head;
            case (state_reg)
                ST_DELIM:
                begin
                    out_item_next.out_byte = delim_reg;
                    out_item_next.last     = !quote_on_reg && src_empty;
                    if (quote_on_reg)
                    begin
                        state_next = ST_OPENQ;
                    end
                    else
                    begin
                        state_next = src_empty ? ST_IDLE : ST_BODY;
                    end
                end
                ST_OPENQ:
                begin
                    out_item_next.out_byte = quote_reg;
                    state_next = src_empty ? ST_CLOSEQ : ST_BODY;
                end
                ST_BODY:
                begin
                    if (!body_pop)
                    begin
                        out_item_next.out_byte = quote_reg;
                        dbl_next = 1'b1;
                    end
                    else
                    begin
                        dbl_next = 1'b0;
                        out_item_next.last = !src_more && !quote_on_reg;
                        if (src_null_reg)
                        begin
                            null_sh_next = null_sh_reg >> 8;
                            ncnt_next    = ncnt_reg - 4'd1;
                        end
                        if (!src_more)
                        begin
                            state_next = quote_on_reg ? ST_CLOSEQ : ST_IDLE;
                        end
                    end
                end
                ST_CLOSEQ:
                begin
                    out_item_next.out_byte = quote_reg;
                    out_item_next.last     = 1'b1;
                    state_next             = ST_IDLE;
                end
                ST_CR:
                begin
                    out_item_next.out_byte = CHAR_CR;
                    state_next             = ST_LF;
                end
                ST_LF:
                begin
                    out_item_next.out_byte = CHAR_LF;
                    out_item_next.last     = 1'b1;
                    state_next             = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            delim_reg     <= RESET_DELIMITER;
            quote_reg     <= RESET_QUOTE_MARK;
            aq_reg        <= 1'b0;
            crlf_reg      <= 1'b0;
            null_text_reg <= '0;
            null_len_reg  <= '0;
            special_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            rhf_reg       <= 1'b0;
            rows_reg      <= '0;
            trunc_reg     <= 1'b0;
            quote_on_reg  <= 1'b0;
            src_null_reg  <= 1'b0;
            dbl_reg       <= 1'b0;
            ncnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            special_reg   <= special_next;
            ovf_reg       <= ovf_next;
            rhf_reg       <= rhf_next;
            rows_reg      <= rows_next;
            trunc_reg     <= trunc_next;
            quote_on_reg  <= quote_on_next;
            src_null_reg  <= src_null_next;
            dbl_reg       <= dbl_next;
            ncnt_reg      <= ncnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DELIMITER:    delim_reg     <= cfg_data[7:0];
                    REG_QUOTE_MARK:   quote_reg     <= cfg_data[7:0];
                    REG_ALWAYS_QUOTE: aq_reg        <= cfg_data[0];
                    REG_USE_CRLF:     crlf_reg      <= cfg_data[0];
                    REG_NULL_TEXT:    null_text_reg <= cfg_data;
                    REG_NULL_LENGTH:  null_len_reg  <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        null_sh_reg  <= null_sh_next;
        out_item_reg <= out_item_next;
    end

endmodule

### sv/csvw_cell.sv
// one byte cell of the field chain
module csvw_cell
    import csvw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_ctl_t ctl,
    input  logic       prev_valid,
    input  cell_t      nxt,
    output cell_t      cur
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.pop)
        begin
            valid_next = nxt.valid;
            data_next  = nxt.data;
        end
        else if (ctl.load && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            data_next  = ctl.load_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign cur.valid = valid_reg;
    assign cur.data  = data_reg;

endmodule

### sv/csvw_chain.sv
// row of byte cells holding the pending field, head at cell zero
module csvw_chain
    import csvw_pkg::*;
#(
    parameter int Depth = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_ctl_t ctl,
    output logic [7:0] head,
    output logic       head_valid,
    output logic       second_valid,
    output logic       full
);

    cell_t cells [Depth];

    genvar i;
    generate
        for (i = 0; i < Depth; i++)
        begin : g_cell
            logic  prev_valid;
            cell_t nxt;

            if (i == 0)
            begin : g_first
                assign prev_valid = 1'b1;
            end
            else
            begin : g_mid
                assign prev_valid = cells[i-1].valid;
            end

            if (i == Depth - 1)
            begin : g_tail
                assign nxt = '0;
            end
            else
            begin : g_body
                assign nxt = cells[i+1];
            end

            csvw_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_valid (prev_valid),
                .nxt        (nxt),
                .cur        (cells[i])
            );
        end

        if (Depth > 1)
        begin : g_second
            assign second_valid = cells[1].valid;
        end
        else
        begin : g_no_second
            assign second_valid = 1'b0;
        end
    endgenerate

    assign head       = cells[0].data;
    assign head_valid = cells[0].valid;
    assign full       = cells[Depth-1].valid;

endmodule
